>>> hdl/shs_pkg.sv
// Shared types, constants and SHA-256 bit functions for the streaming hasher.
// Used by the compression core and the top level.
package shs_pkg;

  typedef logic [7:0][31:0] chain_t;

  typedef struct packed {
    logic load;
    logic start;
    logic init;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
  } core_status_t;

  localparam chain_t INITIAL_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  function automatic logic [31:0] ch_f(input logic [31:0] e, input logic [31:0] f,
                                       input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] maj_f(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

>>> hdl/shs_channels.sv
// Valid/ready channel interfaces for the streaming hasher.
// Depends on nothing; the top level uses one input and one output channel.
interface shs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source(output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink(input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface shs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source(output valid, digest_word, word_index, last_word, input ready);
  modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> hdl/sha256_stream_hasher_unit.sv
// Streaming SHA-256 hasher top level: byte intake, padding sequencer and
// digest output. Depends on shs_pkg, shs_channels and shs_core.
//
// Usage: each transfer on data_in may carry one message byte (byte_valid)
// and may end the message (end_of_message); an item with neither is a no-op.
// A byte that does not complete a 64-byte block is stored and data_in stays ready. A byte that
// completes a block starts a compression in the shared round unit, which
// runs one round per cycle; data_in is not ready until the compression ends.
// Ending a message inserts the padding bytes one per cycle into the block
// register and runs one or two further compressions, depending on how
// full the last block was. The digest then leaves on digest_out as four
// 64-bit transfers, most significant word first, the last one flagged.
// While the receiver stalls, the current word is held and no input is taken.
// After the fourth transfer the chain value, byte count and bit count return
// to their initial values. A synchronous reset has the same effect and
// drops any message in progress.
module sha256_stream_hasher_unit
  import shs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  shs_in_if.sink    data_in,
  shs_out_if.source digest_out
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_BLK_START = 7'b0000010,
    S_BLK_WAIT  = 7'b0000100,
    S_PAD       = 7'b0001000,
    S_PAD_START = 7'b0010000,
    S_PAD_WAIT  = 7'b0100000,
    S_OUT       = 7'b1000000
  } top_state_t;

  top_state_t   state;
  logic [5:0]   fill;
  logic [63:0]  message_bits;
  logic         pend_end;
  logic         len_blk;
  logic         first_pad;
  logic [1:0]   idx;

  core_ctrl_t   ctrl;
  core_status_t status;
  chain_t       chain;
  logic [7:0]   load_byte;
  logic [7:0]   pad_byte;
  logic [5:0]   fill_after;
  logic         in_xfer;
  logic         out_xfer;

  assign in_xfer  = data_in.valid && data_in.ready;
  assign out_xfer = digest_out.valid && digest_out.ready;
  assign fill_after = fill + {5'd0, data_in.byte_valid};

  always_comb begin
    if (first_pad) begin
      pad_byte = PAD_MARK;
    end else if (len_blk && (fill[5:3] == 3'b111)) begin
      pad_byte = 8'(message_bits >> {3'd7 - fill[2:0], 3'b000});
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    ctrl.load  = (in_xfer && data_in.byte_valid) || (state == S_PAD);
    ctrl.start = (state == S_BLK_START) || (state == S_PAD_START);
    ctrl.init  = out_xfer && (idx == 2'd3);
    load_byte  = (state == S_PAD) ? pad_byte : data_in.data_byte;
  end

  shs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .load_byte (load_byte),
    .status    (status),
    .chain     (chain)
  );

  assign data_in.ready          = (state == S_IDLE);
  assign digest_out.valid       = (state == S_OUT);
  assign digest_out.digest_word = {chain[{idx, 1'b0}], chain[{idx, 1'b1}]};
  assign digest_out.word_index  = idx;
  assign digest_out.last_word   = (idx == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      message_bits <= '0;
      pend_end     <= 1'b0;
      len_blk      <= 1'b0;
      first_pad    <= 1'b0;
      idx          <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (data_in.byte_valid) begin
              fill         <= fill_after;
              message_bits <= message_bits + 64'd8;
            end
            if (data_in.byte_valid && (fill == 6'd63)) begin
              pend_end <= data_in.end_of_message;
              state    <= S_BLK_START;
            end else if (data_in.end_of_message) begin
              first_pad <= 1'b1;
              len_blk   <= (fill_after <= 6'd55);
              state     <= S_PAD;
            end
          end
        end
        S_BLK_START: begin
          state <= S_BLK_WAIT;
        end
        S_BLK_WAIT: begin
          if (!status.busy) begin
            if (pend_end) begin
              first_pad <= 1'b1;
              len_blk   <= 1'b1;
              state     <= S_PAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_PAD: begin
          fill      <= fill + 6'd1;
          first_pad <= 1'b0;
          if (fill == 6'd63) begin
            state <= S_PAD_START;
          end
        end
        S_PAD_START: begin
          state <= S_PAD_WAIT;
        end
        S_PAD_WAIT: begin
          if (!status.busy) begin
            if (len_blk) begin
              idx   <= '0;
              state <= S_OUT;
            end else begin
              len_blk <= 1'b1;
              state   <= S_PAD;
            end
          end
        end
        S_OUT: begin
          if (out_xfer) begin
            idx <= idx + 2'd1;
            if (idx == 2'd3) begin
              fill         <= '0;
              message_bits <= '0;
              state        <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/shs_core.sv
// SHA-256 compression core: a 512-bit block shift register, the chain value
// and one round unit reused for every round of a block. Depends on shs_pkg.
module shs_core
  import shs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  core_ctrl_t   ctrl,
  input  logic [7:0]   load_byte,
  output core_status_t status,
  output chain_t       chain
);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_ADD   = 3'b100
  } core_state_t;

  core_state_t    state;
  logic [5:0]     rnd;
  logic [511:0]   block;
  logic [7:0][31:0] v;

  logic [31:0] w0, w1, w9, w14, wnew, t1, t2;

  always_comb begin
    w0   = block[511:480];
    w1   = block[479:448];
    w9   = block[223:192];
    w14  = block[63:32];
    wnew = w0 + ssig0(w1) + w9 + ssig1(w14);
    t1   = v[7] + bsig1(v[4]) + ch_f(v[4], v[5], v[6]) + ROUND_K[rnd] + w0;
    t2   = bsig0(v[0]) + maj_f(v[0], v[1], v[2]);
  end

  assign status.busy = (state != C_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      rnd   <= '0;
      chain <= INITIAL_HASH;
    end else begin
      case (state)
        C_IDLE: begin
          if (ctrl.init) begin
            chain <= INITIAL_HASH;
          end
          if (ctrl.start) begin
            rnd   <= '0;
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= C_ADD;
          end
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          state <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == C_IDLE) begin
      if (ctrl.load) begin
        block <= {block[503:0], load_byte};
      end
      if (ctrl.start) begin
        v <= chain;
      end
    end else if (state == C_ROUND) begin
      block <= {block[479:0], wnew};
      v[7]  <= v[6];
      v[6]  <= v[5];
      v[5]  <= v[4];
      v[4]  <= v[3] + t1;
      v[3]  <= v[2];
      v[2]  <= v[1];
      v[1]  <= v[0];
      v[0]  <= t1 + t2;
    end
  end

endmodule
